// ===== rtl/ddc_ci_vcp_framer_checker_top_defines.svh =====
// Assertion macros for the DDC/CI VCP framer and reply checker.
// Included by the top level; needs no package.
`ifndef DDC_CI_VCP_FRAMER_CHECKER_TOP_DEFINES_SVH
`define DDC_CI_VCP_FRAMER_CHECKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ddc_vcp_pkg.sv =====
// Shared types and protocol constants for the DDC/CI VCP framer and checker.
// No dependencies.
package ddc_vcp_pkg;

    // frame bytes
    localparam logic [7:0] HOST_ADDR    = 8'h6E;
    localparam logic [7:0] SRC_ADDR     = 8'h51;
    localparam logic [7:0] SET_LEN_BYTE = 8'h84;
    localparam logic [7:0] SET_OPCODE   = 8'h03;
    localparam logic [7:0] GET_LEN_BYTE = 8'h82;
    localparam logic [7:0] GET_OPCODE   = 8'h01;
    localparam logic [7:0] REPLY_SEED   = 8'h6F;
    localparam logic [7:0] REPLY_OPCODE = 8'h02;

    localparam int         REPLY_LENGTH   = 11;
    localparam logic [3:0] REPLY_LAST_IDX = 4'(REPLY_LENGTH - 1);

    // byte positions inside a reply
    localparam logic [3:0] RPL_POS_DEST = 4'd0;
    localparam logic [3:0] RPL_POS_OPC  = 4'd2;
    localparam logic [3:0] RPL_POS_CODE = 4'd4;
    localparam logic [3:0] RPL_POS_MAX  = 4'd7;
    localparam logic [3:0] RPL_POS_CUR  = 4'd9;

    // last byte index of each frame
    localparam logic [2:0] SET_LAST_IDX = 3'd6;
    localparam logic [2:0] GET_LAST_IDX = 3'd4;

    localparam logic [3:0] MAX_TRIES_RESET   = 4'd10;
    localparam logic       REG_IDX_MAX_TRIES = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_REPLY = 2'd2,
        OP_FAIL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        JOB_SET = 2'd0,
        JOB_GET = 2'd1,
        JOB_RES = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  code;
        logic [15:0] value;
        logic        ok;
        logic [7:0]  max_v;
        logic [7:0]  cur_v;
        logic [3:0]  tries;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/ddc_vcp_front.sv =====
// Front end: accepts input requests, tracks the get/reply state and
// classifies each request into at most one output job. Uses ddc_vcp_pkg.
module ddc_vcp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_code,
    input  logic [15:0]         i_value,
    input  logic [7:0]          i_rx,
    input  logic [3:0]          i_max_tries,
    input  ddc_vcp_pkg::t_q_status i_q_status,
    output logic                o_push,
    output ddc_vcp_pkg::t_job   o_job
);
    import ddc_vcp_pkg::*;

    logic       r_await, n_await;
    logic [7:0] r_pend, n_pend;
    logic [3:0] r_try, n_try;
    logic [3:0] r_idx, n_idx;
    logic [7:0] r_xor, n_xor;
    logic       r_hdr, n_hdr;
    logic [7:0] r_cmax, n_cmax;
    logic [7:0] r_ccur, n_ccur;

    logic acc;
    logic start_req, fail_att, res_ok;

    assign o_ready = !i_q_status.full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_await   = r_await;
        n_pend    = r_pend;
        n_try     = r_try;
        n_idx     = r_idx;
        n_xor     = r_xor;
        n_hdr     = r_hdr;
        n_cmax    = r_cmax;
        n_ccur    = r_ccur;
        start_req = 1'b0;
        fail_att  = 1'b0;
        res_ok    = 1'b0;
        o_push    = 1'b0;
        o_job.kind  = JOB_RES;
        o_job.code  = r_pend;
        o_job.value = '0;
        o_job.ok    = 1'b0;
        o_job.max_v = '0;
        o_job.cur_v = '0;
        o_job.tries = r_try;

        if (acc) begin
            case (t_op'(i_op))
                OP_SET: begin
                    n_await     = 1'b0;
                    n_idx       = '0;
                    o_push      = 1'b1;
                    o_job.kind  = JOB_SET;
                    o_job.code  = i_code;
                    o_job.value = i_value;
                end
                OP_GET: begin
                    n_pend    = i_code;
                    n_try     = 4'd1;
                    start_req = 1'b1;
                end
                OP_REPLY: begin
                    if (r_await) begin
                        if (r_idx >= REPLY_LAST_IDX) begin
                            if (r_hdr && i_rx == r_xor) begin
                                res_ok = 1'b1;
                            end else begin
                                fail_att = 1'b1;
                            end
                        end else begin
                            case (r_idx)
                                RPL_POS_DEST: if (i_rx != HOST_ADDR) n_hdr = 1'b0;
                                RPL_POS_OPC:  if (i_rx != REPLY_OPCODE) n_hdr = 1'b0;
                                RPL_POS_CODE: if (i_rx != r_pend) n_hdr = 1'b0;
                                RPL_POS_MAX:  n_cmax = i_rx;
                                RPL_POS_CUR:  n_ccur = i_rx;
                                default: ;
                            endcase
                            // the destination byte is not part of the checksum
                            if (r_idx != RPL_POS_DEST) begin
                                n_xor = r_xor ^ i_rx;
                            end
                            n_idx = r_idx + 4'd1;
                        end
                    end
                end
                OP_FAIL: begin
                    if (r_await) begin
                        fail_att = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (fail_att) begin
            if (r_try >= i_max_tries) begin
                n_await     = 1'b0;
                n_idx       = '0;
                o_push      = 1'b1;
                o_job.kind  = JOB_RES;
                o_job.tries = r_try;
            end else begin
                n_try     = r_try + 4'd1;
                start_req = 1'b1;
            end
        end

        if (res_ok) begin
            n_await     = 1'b0;
            n_idx       = '0;
            o_push      = 1'b1;
            o_job.kind  = JOB_RES;
            o_job.ok    = 1'b1;
            o_job.max_v = r_cmax;
            o_job.cur_v = r_ccur;
            o_job.tries = r_try;
        end

        if (start_req) begin
            n_await    = 1'b1;
            n_idx      = '0;
            n_xor      = REPLY_SEED ^ SRC_ADDR;
            n_hdr      = 1'b1;
            n_cmax     = '0;
            n_ccur     = '0;
            o_push     = 1'b1;
            o_job.kind = JOB_GET;
            o_job.code = n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_pend  <= '0;
            r_try   <= '0;
            r_idx   <= '0;
            r_xor   <= '0;
            r_hdr   <= 1'b1;
            r_cmax  <= '0;
            r_ccur  <= '0;
        end else begin
            r_await <= n_await;
            r_pend  <= n_pend;
            r_try   <= n_try;
            r_idx   <= n_idx;
            r_xor   <= n_xor;
            r_hdr   <= n_hdr;
            r_cmax  <= n_cmax;
            r_ccur  <= n_ccur;
        end
    end

endmodule

// ===== rtl/ddc_vcp_queue.sv =====
// Small job queue between the front end and the byte serializer.
// Uses ddc_vcp_pkg (t_job, t_q_status, QUEUE_DEPTH).
module ddc_vcp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ddc_vcp_pkg::t_job      i_job,
    input  logic                   i_pop,
    output ddc_vcp_pkg::t_job      o_head,
    output ddc_vcp_pkg::t_q_status o_status
);
    import ddc_vcp_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, n_wp;
    logic [QUEUE_AW-1:0] r_rp, n_rp;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_status.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/ddc_vcp_back.sv =====
// Back end: turns the queue head job into frame bytes or a get result, one
// per unstalled cycle, into a registered output stage. Uses ddc_vcp_pkg.
module ddc_vcp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ddc_vcp_pkg::t_job      i_head,
    input  ddc_vcp_pkg::t_q_status i_q_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_kind,
    output logic [7:0]             o_tx_byte,
    output logic                   o_last,
    output logic                   o_success,
    output logic [7:0]             o_rpt_max,
    output logic [7:0]             o_rpt_cur,
    output logic [3:0]             o_tries_used
);
    import ddc_vcp_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    logic       r_kind, r_last, r_success;
    logic [7:0] r_tx, r_max, r_cur;
    logic [3:0] r_tries;

    logic       advance, take;
    logic       c_kind, c_last;
    logic [7:0] c_tx, c_max, c_cur;
    logic [3:0] c_tries;
    logic [7:0] set_sum, get_sum;

    assign set_sum = HOST_ADDR ^ SRC_ADDR ^ SET_LEN_BYTE ^ SET_OPCODE ^ i_head.code
                   ^ i_head.value[15:8] ^ i_head.value[7:0];
    assign get_sum = HOST_ADDR ^ SRC_ADDR ^ GET_LEN_BYTE ^ GET_OPCODE ^ i_head.code;

    always_comb begin
        c_kind  = 1'b0;
        c_tx    = '0;
        c_last  = 1'b1;
        c_max   = '0;
        c_cur   = '0;
        c_tries = '0;
        case (i_head.kind)
            JOB_SET: begin
                c_last = (r_idx == SET_LAST_IDX);
                case (r_idx)
                    3'd0:    c_tx = SRC_ADDR;
                    3'd1:    c_tx = SET_LEN_BYTE;
                    3'd2:    c_tx = SET_OPCODE;
                    3'd3:    c_tx = i_head.code;
                    3'd4:    c_tx = i_head.value[15:8];
                    3'd5:    c_tx = i_head.value[7:0];
                    default: c_tx = set_sum;
                endcase
            end
            JOB_GET: begin
                c_last = (r_idx == GET_LAST_IDX);
                case (r_idx)
                    3'd0:    c_tx = SRC_ADDR;
                    3'd1:    c_tx = GET_LEN_BYTE;
                    3'd2:    c_tx = GET_OPCODE;
                    3'd3:    c_tx = i_head.code;
                    default: c_tx = get_sum;
                endcase
            end
            default: begin
                c_kind  = 1'b1;
                c_max   = i_head.max_v;
                c_cur   = i_head.cur_v;
                c_tries = i_head.tries;
            end
        endcase
    end

    // output stage refills whenever it is empty or being drained
    assign advance = !r_valid || i_ready;
    assign take    = advance && !i_q_status.empty;
    assign o_pop   = take && c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (advance) begin
                r_valid <= !i_q_status.empty;
            end
            if (take) begin
                r_idx <= c_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind    <= c_kind;
            r_tx      <= c_tx;
            r_last    <= c_last;
            r_success <= c_kind && i_head.ok;
            r_max     <= c_max;
            r_cur     <= c_cur;
            r_tries   <= c_tries;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx;
    assign o_last       = r_last;
    assign o_success    = r_success;
    assign o_rpt_max    = r_max;
    assign o_rpt_cur    = r_cur;
    assign o_tries_used = r_tries;

endmodule

// ===== rtl/ddc_ci_vcp_framer_checker_top.sv =====
// Top level of the DDC/CI VCP set/get framer and reply checker.
// Uses ddc_vcp_pkg, ddc_vcp_front, ddc_vcp_queue, ddc_vcp_back and the defines header.

// Host side of DDC/CI VCP feature access. A set request yields a 7-byte frame, a get
// request a 5-byte frame, and the 11 reply bytes then fed back are checked; a good
// reply or an exhausted retry count yields one result item (tuser=1). The input side
// takes one request per cycle while the 4-entry job queue has room; each request
// leaves at most one job there. The output serializer sends one item per cycle unless
// m_axis_tready stalls it; a set yields 7 items, a get request 5 and a result 1, and
// it sets the sustained rate. max_tries sits at APB byte address 0 (reset 10).
`include "ddc_ci_vcp_framer_checker_top_defines.svh"

module ddc_ci_vcp_framer_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // feature_code[7:0], set_word[23:8], rx_byte[31:24]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // tx_byte[7:0], success[8], rpt_max[16:9],
                                        // rpt_cur[24:17], tries_used[28:25], zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // kind[0]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ddc_vcp_pkg::*;

    logic [3:0] r_max_tries;

    t_job      push_job, head_job;
    logic      push, pop;
    t_q_status q_status;

    logic       out_success;
    logic [7:0] out_tx, out_max, out_cur;
    logic [3:0] out_tries;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_MAX_TRIES) ? {28'd0, r_max_tries} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries <= MAX_TRIES_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_MAX_TRIES) begin
            r_max_tries <= pwdata[3:0];
        end
    end

    ddc_vcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_code      (s_axis_tdata[7:0]),
        .i_value     (s_axis_tdata[23:8]),
        .i_rx        (s_axis_tdata[31:24]),
        .i_max_tries (r_max_tries),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (push_job)
    );

    ddc_vcp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    ddc_vcp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (m_axis_tuser),
        .o_tx_byte    (out_tx),
        .o_last       (m_axis_tlast),
        .o_success    (out_success),
        .o_rpt_max    (out_max),
        .o_rpt_cur    (out_cur),
        .o_tries_used (out_tries)
    );

    assign m_axis_tdata = {3'd0, out_tries, out_cur, out_max, out_success, out_tx};

    // a result is always a single, final item
    `ASSERT_IMPL(a_result_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // a failed get reports zero values
    `ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser && !out_success, out_max == 8'd0 && out_cur == 8'd0)
    // the queue can never be full and empty together
    `ASSERT_IMPL(a_queue_sane, i_clk, i_rst_n, 1'b1, !(q_status.full && q_status.empty))
    // a pop always takes the final item of a job into the output stage
    `ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, pop, m_axis_tvalid && m_axis_tlast)

endmodule
